[src/mlc_pkg.sv]
// ----------------------------------------------------------------------------
// mlc_pkg: shared types, constants and arithmetic helpers
// Types, threshold reset values and divide-by-constant helpers used by the
// motion level classifier and its submodules.
// ----------------------------------------------------------------------------
package mlc_pkg;

   // Width of every average and threshold
   localparam int AVG_BITS = 15;
   localparam int SUM_BITS = 21;   // holds avg*59 + x for 15-bit values

   localparam logic [AVG_BITS-1:0] AVG_MAX        = 15'h7fff;
   localparam logic [AVG_BITS-1:0] STILL_RESET    = 15'd50;
   localparam logic [AVG_BITS-1:0] HANDHELD_RESET = 15'd250;

   // Register indexes on the configuration port (byte address bit 2)
   localparam logic CSR_IDX_STILL    = 1'b0;
   localparam logic CSR_IDX_HANDHELD = 1'b1;

   // Reciprocals for floor division, exact over the operand ranges used below
   localparam int  DIV_SHIFT  = 23;
   localparam logic [43:0] DIV5_MUL  = 44'd1677722;  // ceil(2^23 / 5)
   localparam logic [43:0] DIV15_MUL = 44'd559241;   // ceil(2^23 / 15)

   typedef enum logic [1:0] {
      CLASS_STILL    = 2'd0,
      CLASS_HANDHELD = 2'd1,
      CLASS_SHAKING  = 2'd2
   } motion_class_type;

   typedef struct packed {
      logic [AVG_BITS-1:0] short_avg;
      logic [AVG_BITS-1:0] medium_avg;
      logic [AVG_BITS-1:0] long_avg;
   } avg_set_type;

   // floor(v / 5) for v below 2^20
   function automatic logic [19:0] div5(input logic [19:0] v);
      logic [43:0] prod;
      prod = 44'(v) * DIV5_MUL;
      return prod[DIV_SHIFT +: 20];
   endfunction

   // floor(v / 15) for v below 2^19
   function automatic logic [18:0] div15(input logic [18:0] v);
      logic [43:0] prod;
      prod = 44'(v) * DIV15_MUL;
      return prod[DIV_SHIFT +: 19];
   endfunction

   // (avg*9 + x) / 10
   function automatic logic [AVG_BITS-1:0] leak10(input logic [AVG_BITS-1:0] avg,
                                                  input logic [AVG_BITS-1:0] x);
      logic [SUM_BITS-1:0] sum;
      logic [19:0]         q;
      sum = (SUM_BITS'(avg) << 3) + SUM_BITS'(avg) + SUM_BITS'(x);
      q   = div5(sum[20:1]);
      return q[AVG_BITS-1:0];
   endfunction

   // (avg*19 + x) / 20
   function automatic logic [AVG_BITS-1:0] leak20(input logic [AVG_BITS-1:0] avg,
                                                  input logic [AVG_BITS-1:0] x);
      logic [SUM_BITS-1:0] sum;
      logic [19:0]         q;
      sum = (SUM_BITS'(avg) << 4) + (SUM_BITS'(avg) << 1) + SUM_BITS'(avg)
            + SUM_BITS'(x);
      q   = div5({1'b0, sum[20:2]});
      return q[AVG_BITS-1:0];
   endfunction

   // (avg*59 + x) / 60
   function automatic logic [AVG_BITS-1:0] leak60(input logic [AVG_BITS-1:0] avg,
                                                  input logic [AVG_BITS-1:0] x);
      logic [SUM_BITS-1:0] sum;
      logic [18:0]         q;
      sum = (SUM_BITS'(avg) << 6) - (SUM_BITS'(avg) << 2) - SUM_BITS'(avg)
            + SUM_BITS'(x);
      q   = div15(sum[20:2]);
      return q[AVG_BITS-1:0];
   endfunction

endpackage

[src/mlc_ema_bank.sv]
// ----------------------------------------------------------------------------
// mlc_ema_bank: next values of the three leaky averages
// Loads the sample into all averages on the first request after reset and
// otherwise applies the window-10, -20 and -60 leaky updates.
// ----------------------------------------------------------------------------
module mlc_ema_bank (
   input  logic                          primed,
   input  logic [mlc_pkg::AVG_BITS-1:0]  sample,
   input  mlc_pkg::avg_set_type          avg_cur,
   output mlc_pkg::avg_set_type          avg_next
);
   import mlc_pkg::*;

   // Load on the first sample, leak afterwards
   always_comb begin
      if (primed) begin
         avg_next.short_avg  = leak10(avg_cur.short_avg, sample);
         avg_next.medium_avg = leak20(avg_cur.medium_avg, sample);
         avg_next.long_avg   = leak60(avg_cur.long_avg, sample);
      end else begin
         avg_next.short_avg  = sample;
         avg_next.medium_avg = sample;
         avg_next.long_avg   = sample;
      end
   end

endmodule

[src/mlc_classify.sv]
// ----------------------------------------------------------------------------
// mlc_classify: threshold classifier
// Compares the three averages against the still and handheld thresholds;
// the still test takes priority.
// ----------------------------------------------------------------------------
module mlc_classify (
   input  mlc_pkg::avg_set_type          avgs,
   input  logic [mlc_pkg::AVG_BITS-1:0]  still_threshold,
   input  logic [mlc_pkg::AVG_BITS-1:0]  handheld_threshold,
   output mlc_pkg::motion_class_type     motion_class
);
   import mlc_pkg::*;

   logic all_still;
   logic all_handheld;

   assign all_still = (avgs.short_avg < still_threshold) &&
                      (avgs.medium_avg < still_threshold) &&
                      (avgs.long_avg < still_threshold);

   assign all_handheld = (avgs.short_avg < handheld_threshold) &&
                         (avgs.medium_avg < handheld_threshold) &&
                         (avgs.long_avg < handheld_threshold);

   // Pick the lowest class whose test passes
   always_comb begin
      if (all_still) begin
         motion_class = CLASS_STILL;
      end else if (all_handheld) begin
         motion_class = CLASS_HANDHELD;
      end else begin
         motion_class = CLASS_SHAKING;
      end
   end

endmodule

[src/motion_level_classifier.sv]
// ----------------------------------------------------------------------------
// motion_level_classifier: motion level classifier on leaky averages
// Top level: request register, average state, result register and the
// threshold registers on an APB-style port.
// ----------------------------------------------------------------------------
// The block takes one signed motion sample per request, clamps it to
// 0..32767, updates three leaky averages (windows 10, 20 and 60; the first
// sample after reset loads them directly) and returns the averages together
// with a class: still, handheld or shaking. It accepts one request every
// clock cycle unless a stalled result backs up the request register; a
// request passes from the request register to the result register, and the
// average update, constant divides and compares are combinational between
// those two registers. Thresholds sit at byte addresses 0 (still) and 4
// (handheld) and must be written while no request is in flight.
module motion_level_classifier #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [SAMPLE_BITS-1:0]        req_motion_sample,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_motion_class,
   output logic [mlc_pkg::AVG_BITS-1:0]  rsp_short_average,
   output logic [mlc_pkg::AVG_BITS-1:0]  rsp_medium_average,
   output logic [mlc_pkg::AVG_BITS-1:0]  rsp_long_average,

   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [2:0]                    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import mlc_pkg::*;

   // Wide enough for any sample width and for the average range
   localparam int EXT_BITS = SAMPLE_BITS + AVG_BITS + 1;

   // Threshold registers
   logic [AVG_BITS-1:0] still_thr_ff,    still_thr_in;
   logic [AVG_BITS-1:0] handheld_thr_ff, handheld_thr_in;

   // Request stage
   logic                in_valid_ff,  in_valid_in;
   logic [AVG_BITS-1:0] in_sample_ff, in_sample_in;

   // Average state
   logic                primed_ff,    primed_in;
   avg_set_type         avg_ff,       avg_in;

   // Result stage
   logic                rsp_valid_ff, rsp_valid_in;
   motion_class_type    rsp_class_ff, rsp_class_in;
   avg_set_type         rsp_avg_ff,   rsp_avg_in;

   logic                csr_write;
   logic                load_in;
   logic                out_open;
   logic                fire;
   logic [EXT_BITS-1:0] sample_ext;
   logic [AVG_BITS-1:0] sample_clamped;
   avg_set_type         avg_next;
   motion_class_type    class_next;

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;

   always_comb begin
      still_thr_in    = still_thr_ff;
      handheld_thr_in = handheld_thr_ff;
      if (csr_write) begin
         case (paddr[2])
            CSR_IDX_STILL:    still_thr_in    = pwdata[AVG_BITS-1:0];
            CSR_IDX_HANDHELD: handheld_thr_in = pwdata[AVG_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         CSR_IDX_STILL:    prdata = 32'(still_thr_ff);
         CSR_IDX_HANDHELD: prdata = 32'(handheld_thr_ff);
         default:          prdata = '0;
      endcase
   end

   // ---------------- handshake ----------------
   assign out_open  = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_open;
   assign req_stall = in_valid_ff && !out_open;
   assign load_in   = req_valid && !req_stall;

   // Clamp negatives to zero and large values to the average range
   assign sample_ext = EXT_BITS'(req_motion_sample);

   always_comb begin
      if (req_motion_sample[SAMPLE_BITS-1]) begin
         sample_clamped = '0;
      end else if (sample_ext > EXT_BITS'(AVG_MAX)) begin
         sample_clamped = AVG_MAX;
      end else begin
         sample_clamped = sample_ext[AVG_BITS-1:0];
      end
   end

   // Capture a request, drop it once it moves to the result stage
   always_comb begin
      in_sample_in = in_sample_ff;
      if (load_in) begin
         in_valid_in  = 1'b1;
         in_sample_in = sample_clamped;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // ---------------- datapath ----------------
   mlc_ema_bank u_ema (
      .primed   (primed_ff),
      .sample   (in_sample_ff),
      .avg_cur  (avg_ff),
      .avg_next (avg_next)
   );

   mlc_classify u_classify (
      .avgs               (avg_next),
      .still_threshold    (still_thr_ff),
      .handheld_threshold (handheld_thr_ff),
      .motion_class       (class_next)
   );

   // Advance state and result together; hold a stalled result
   always_comb begin
      primed_in    = primed_ff;
      avg_in       = avg_ff;
      rsp_class_in = rsp_class_ff;
      rsp_avg_in   = rsp_avg_ff;
      if (fire) begin
         primed_in    = 1'b1;
         avg_in       = avg_next;
         rsp_valid_in = 1'b1;
         rsp_class_in = class_next;
         rsp_avg_in   = avg_next;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         still_thr_ff    <= STILL_RESET;
         handheld_thr_ff <= HANDHELD_RESET;
         in_valid_ff     <= 1'b0;
         primed_ff       <= 1'b0;
         avg_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         still_thr_ff    <= still_thr_in;
         handheld_thr_ff <= handheld_thr_in;
         in_valid_ff     <= in_valid_in;
         primed_ff       <= primed_in;
         avg_ff          <= avg_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      in_sample_ff <= in_sample_in;
      rsp_class_ff <= rsp_class_in;
      rsp_avg_ff   <= rsp_avg_in;
   end

   // ---------------- outputs ----------------
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_motion_class   = rsp_class_ff;
   assign rsp_short_average  = rsp_avg_ff.short_avg;
   assign rsp_medium_average = rsp_avg_ff.medium_avg;
   assign rsp_long_average   = rsp_avg_ff.long_avg;

`ifndef SYNTHESIS
   // Once primed, stay primed until reset
   a_primed_sticky: assert property (@(posedge clock) disable iff (reset)
      primed_ff |=> primed_ff)
      else $error("primed flag cleared without reset");

   // Request side stalls only behind a stalled, full result stage
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid_ff && rsp_stall && in_valid_ff))
      else $error("request stalled without a blocked result");

   // A still result has every average below the still threshold
   a_still_class: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_class_ff == CLASS_STILL) |->
         (rsp_avg_ff.short_avg < still_thr_ff &&
          rsp_avg_ff.medium_avg < still_thr_ff &&
          rsp_avg_ff.long_avg < still_thr_ff))
      else $error("still class with an average at or above threshold");

   // Result state mirrors the stored averages right after an update
   a_avg_match: assert property (@(posedge clock) disable iff (reset)
      fire |=> (rsp_avg_ff == avg_ff && rsp_valid_ff))
      else $error("result averages differ from stored averages");
`endif

endmodule

[dv/motion_level_classifier_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// motion_level_classifier_tb: self-checking bench for the motion classifier
// Sends signed motion samples through the request channel under several
// threshold settings and random flow control. It predicts the three leaky
// averages and the class for every accepted request and compares each
// returned result with the oldest prediction.
// ----------------------------------------------------------------------------

typedef struct {
   mlc_pkg::motion_class_type   cls;
   logic [mlc_pkg::AVG_BITS-1:0] short_avg;
   logic [mlc_pkg::AVG_BITS-1:0] medium_avg;
   logic [mlc_pkg::AVG_BITS-1:0] long_avg;
} motion_result_type;

// Average predictor and in-order result checker
class motion_scoreboard;
   logic [mlc_pkg::AVG_BITS-1:0] still_limit;
   logic [mlc_pkg::AVG_BITS-1:0] handheld_limit;
   logic [mlc_pkg::AVG_BITS-1:0] avg_short;
   logic [mlc_pkg::AVG_BITS-1:0] avg_medium;
   logic [mlc_pkg::AVG_BITS-1:0] avg_long;
   bit                           primed;
   motion_result_type            pending[$];
   int                           errors;
   int                           checked;
   int                           class_seen[3];

   function new();
      still_limit    = mlc_pkg::STILL_RESET;
      handheld_limit = mlc_pkg::HANDHELD_RESET;
      avg_short      = '0;
      avg_medium     = '0;
      avg_long       = '0;
      primed         = 1'b0;
      errors         = 0;
      checked        = 0;
      class_seen     = '{0, 0, 0};
   endfunction

   // Keep only the low 15 bits of a written threshold
   function void set_threshold(logic idx, logic [31:0] data);
      if (idx == mlc_pkg::CSR_IDX_STILL)
         still_limit = data[mlc_pkg::AVG_BITS-1:0];
      else
         handheld_limit = data[mlc_pkg::AVG_BITS-1:0];
   endfunction

   function logic [mlc_pkg::AVG_BITS-1:0] leak(logic [mlc_pkg::AVG_BITS-1:0] avg,
                                              logic [mlc_pkg::AVG_BITS-1:0] x, int n);
      return mlc_pkg::AVG_BITS'((int'(avg) * (n - 1) + int'(x)) / n);
   endfunction

   function bit all_below(logic [mlc_pkg::AVG_BITS-1:0] limit);
      return avg_short < limit && avg_medium < limit && avg_long < limit;
   endfunction

   // Advance the averages for one accepted sample and queue the prediction
   function void note_sample(logic [15:0] sample);
      logic [mlc_pkg::AVG_BITS-1:0] x;
      motion_result_type            res;
      x = sample[15] ? '0 : sample[mlc_pkg::AVG_BITS-1:0];
      if (!primed) begin
         avg_short  = x;
         avg_medium = x;
         avg_long   = x;
         primed     = 1'b1;
      end else begin
         avg_short  = leak(avg_short, x, 10);
         avg_medium = leak(avg_medium, x, 20);
         avg_long   = leak(avg_long, x, 60);
      end
      // Still test first, so inverted thresholds hide handheld
      if (all_below(still_limit))
         res.cls = mlc_pkg::CLASS_STILL;
      else if (all_below(handheld_limit))
         res.cls = mlc_pkg::CLASS_HANDHELD;
      else
         res.cls = mlc_pkg::CLASS_SHAKING;
      res.short_avg  = avg_short;
      res.medium_avg = avg_medium;
      res.long_avg   = avg_long;
      pending = {pending, res};
   endfunction

   function void compare_field(string name, int expected, int actual);
      if (expected != actual) begin
         errors++;
         $display("%0t: %s expected %0d, got %0d", $time, name, expected, actual);
      end
   endfunction

   function void check_result(logic [1:0] cls, logic [mlc_pkg::AVG_BITS-1:0] s_avg,
                              logic [mlc_pkg::AVG_BITS-1:0] m_avg,
                              logic [mlc_pkg::AVG_BITS-1:0] l_avg);
      motion_result_type res;
      if (pending.size() == 0) begin
         errors++;
         $display("%0t: result with no request outstanding, expected none, got class %0d",
                  $time, cls);
         return;
      end
      res = pending.pop_front();
      checked++;
      if (res.cls <= mlc_pkg::CLASS_SHAKING)
         class_seen[res.cls]++;
      compare_field("motion_class", res.cls, cls);
      compare_field("short_average", res.short_avg, s_avg);
      compare_field("medium_average", res.medium_avg, m_avg);
      compare_field("long_average", res.long_avg, l_avg);
   endfunction
endclass

module motion_level_classifier_tb;

   localparam int RANDOM_PER_SETTING = 110;
   localparam int NUM_SETTINGS       = 8;
   localparam int LONG_HOLD_CYCLES   = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_motion_sample = '0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b1;
   logic [1:0]  rsp_motion_class;
   logic [mlc_pkg::AVG_BITS-1:0] rsp_short_average;
   logic [mlc_pkg::AVG_BITS-1:0] rsp_medium_average;
   logic [mlc_pkg::AVG_BITS-1:0] rsp_long_average;

   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   motion_scoreboard sb;

   int samples_sent = 0;
   int input_held   = 0;
   bit long_hold_request = 1'b0;

   // Sender idle pattern: runs of quiet (back-to-back) or gappy requests
   int tx_run_left = 0;
   bit tx_quiet    = 1'b0;

   // Current target level for well-formed sample runs
   int level_target = 0;
   int level_left   = 0;

   motion_level_classifier DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_motion_sample  (req_motion_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_motion_class   (rsp_motion_class),
      .rsp_short_average  (rsp_short_average),
      .rsp_medium_average (rsp_medium_average),
      .rsp_long_average   (rsp_long_average),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop in case the block hangs
   initial begin
      #5_000_000;
      $display("motion_level_classifier: mismatch");
      $finish;
   end

   // Check results and count input back-pressure
   always @(posedge clock) begin
      if (!reset && req_valid && req_stall)
         input_held++;
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_motion_class, rsp_short_average, rsp_medium_average,
                         rsp_long_average);
   end

   // Result side: random stall per result, one long hold on request
   initial begin
      int hold;
      int rx_run_left;
      bit rx_quiet;
      rx_run_left = 0;
      rx_quiet    = 1'b0;
      @(negedge clock);
      forever begin
         if (rx_run_left == 0) begin
            rx_run_left = $urandom_range(20, 60);
            rx_quiet    = ($urandom_range(0, 2) == 0);
         end
         rx_run_left--;
         hold = rx_quiet ? 0 : $urandom_range(0, 8);
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            hold = LONG_HOLD_CYCLES;
         end
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // Offer one request after a random gap; entered and left at a falling edge
   task automatic send_sample(input logic [15:0] sample);
      int gap;
      if (tx_run_left == 0) begin
         tx_run_left = $urandom_range(20, 60);
         tx_quiet    = ($urandom_range(0, 2) == 0);
      end
      tx_run_left--;
      gap = tx_quiet ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_motion_sample <= sample;
      do @(posedge clock); while (req_stall);
      sb.note_sample(sample);
      samples_sent++;
      @(negedge clock);
   endtask

   // Drop valid and wait for every outstanding result plus the pipe depth
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_threshold(idx, data);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic csr_read_check(input logic idx);
      logic [mlc_pkg::AVG_BITS-1:0] expected;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      expected = (idx == mlc_pkg::CSR_IDX_STILL) ? sb.still_limit : sb.handheld_limit;
      sb.compare_field(idx == mlc_pkg::CSR_IDX_STILL ? "still_threshold readback" :
                       "handheld_threshold readback", expected,
                       prdata[mlc_pkg::AVG_BITS-1:0]);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   // Mostly runs around a level near the thresholds, with noise mixed in
   function automatic logic [15:0] draw_sample();
      int pick;
      int spread;
      int v;
      pick = $urandom_range(0, 99);
      if (pick < 8)
         return 16'h8000 | 16'($urandom());
      if (pick < 20)
         return 16'($urandom());
      if (pick < 26) begin
         case ($urandom_range(0, 3))
            0: return 16'h0000;
            1: return 16'h7fff;
            2: return 16'hffff;
            default: return 16'h8000;
         endcase
      end
      if (level_left == 0) begin
         level_left = $urandom_range(15, 50);
         case ($urandom_range(0, 5))
            0: level_target = sb.still_limit / 2;
            1: level_target = sb.still_limit;
            2: level_target = (int'(sb.still_limit) + int'(sb.handheld_limit)) / 2;
            3: level_target = sb.handheld_limit + sb.handheld_limit / 4;
            4: level_target = $urandom_range(0, 600);
            default: level_target = $urandom_range(0, 32767);
         endcase
      end
      level_left--;
      spread = level_target / 4 + 8;
      v = level_target - spread / 2 + $urandom_range(0, spread);
      if (v < 0) v = 0;
      if (v > 32767) v = 32767;
      return 16'(v);
   endfunction

   initial begin
      logic [15:0] directed[20];
      int          still_set[NUM_SETTINGS];
      int          handheld_set[NUM_SETTINGS];
      int          phase;
      int          i;

      sb = new();
      // First sample loads the averages; then zero, negatives, extremes
      directed = '{16'd20, 16'd30, 16'd0, 16'hffff, 16'h8000, 16'd1, 16'd49, 16'd50,
                   16'd300, 16'd300, 16'd300, 16'h7fff, 16'h7fff, 16'h5555, 16'haaaa,
                   16'h0100, 16'd0, 16'd0, 16'hfffe, 16'd260};
      // Zero, maximum, inverted and ordinary threshold pairs
      still_set    = '{0, 32767, 400, 0, 200, 0, 32767, 60};
      handheld_set = '{0, 32767, 120, 2000, 3000, 0, 0, 400};
      still_set[5]    = $urandom_range(0, 4000);
      handheld_set[5] = $urandom_range(0, 12000);

      // Hold reset, then release it
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      csr_read_check(mlc_pkg::CSR_IDX_STILL);
      csr_read_check(mlc_pkg::CSR_IDX_HANDHELD);

      foreach (directed[k])
         send_sample(directed[k]);

      for (phase = 0; phase < NUM_SETTINGS; phase++) begin
         drain();
         // Upper data bits are junk and must be dropped
         csr_write(mlc_pkg::CSR_IDX_STILL,
                   {17'($urandom()), 15'(still_set[phase])});
         csr_write(mlc_pkg::CSR_IDX_HANDHELD,
                   {17'($urandom()), 15'(handheld_set[phase])});
         csr_read_check(mlc_pkg::CSR_IDX_STILL);
         csr_read_check(mlc_pkg::CSR_IDX_HANDHELD);
         level_left = 0;
         for (i = 0; i < RANDOM_PER_SETTING; i++) begin
            // Back the result side up once so the block fills
            if (phase == 2 && i == 10) begin
               long_hold_request = 1'b1;
               tx_quiet    = 1'b1;
               tx_run_left = 40;
            end
            send_sample(draw_sample());
         end
      end

      drain();
      repeat (10) @(posedge clock);
      if (sb.pending.size() != 0) begin
         sb.errors++;
         $display("%0t: %0d results expected, got none", $time, sb.pending.size());
      end

      $display("Sent %0d samples over %0d threshold settings; checked %0d results.",
               samples_sent, NUM_SETTINGS + 1, sb.checked);
      $display("Classes still %0d, handheld %0d, shaking %0d; input stalled %0d cycles.",
               sb.class_seen[0], sb.class_seen[1], sb.class_seen[2], input_held);
      if (sb.errors == 0)
         $display("motion_level_classifier: match");
      else
         $display("motion_level_classifier: mismatch");
      $finish;
   end

endmodule
